// ===== sv/message_hash_entropy_kernel_core_assert.svh =====
// Assertion macros for the message hash entropy kernel
`ifndef MESSAGE_HASH_ENTROPY_KERNEL_CORE_ASSERT_SVH
`define MESSAGE_HASH_ENTROPY_KERNEL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is held
`define MHEK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("mhek check failed");
// clocked check that also covers reset
`define MHEK_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
    else $error("mhek reset check failed");
`else
`define MHEK_ASSERT(lbl, prop)
`define MHEK_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== sv/mhek_pkg.sv =====
// Types, constants and helper functions of the message hash entropy kernel
package mhek_pkg;

    localparam int unsigned MAX_MSG_BYTES = 256;
    localparam int unsigned LEN_W = $clog2(MAX_MSG_BYTES + 1);
    localparam int unsigned DIST_W = 9;
    localparam int unsigned SCORE_W = 13;
    localparam int unsigned QT_W = 11;

    // divider widths: transitions*2000 / (len-1)
    localparam int unsigned DV_W = (LEN_W + 11 > 21) ? LEN_W + 11 : 21;
    localparam int unsigned DS_W = (LEN_W > 13) ? LEN_W : 13;
    localparam int unsigned CNT_W = $clog2(DV_W + 1);

    localparam logic [31:0] GOLD       = 32'h9E37_79B9;
    localparam logic [31:0] MIX_KEY    = 32'h5241_4641;
    localparam logic [31:0] SEED_RESET = 32'd1380009537;
    localparam logic [63:0] FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] CHAIN_RESET = 64'(SEED_RESET) * 64'(GOLD);
    localparam logic [7:0]  LEVEL_RESET = 8'd128;
    localparam logic [SCORE_W-1:0] SCORE_CAP = SCORE_W'(8000);

    // score*255/8000 equals score*51/1600, taken as a reciprocal multiply
    localparam logic [19:0] LEVEL_RECIP = 20'd671089;  // ceil(2^30 / 1600)
    localparam int unsigned LEVEL_SHIFT = 30;

    // input op codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // register index (paddr word bit)
    localparam logic REG_SEED = 1'b0;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [15:0]        mix_u;
        logic [15:0]        mix_v;
        logic [15:0]        mix_psi;
        logic [15:0]        mix_chi;
        logic [15:0]        mix_rho;
        logic [15:0]        mix_delta;
        logic [15:0]        mix_sigma;
        logic [7:0]         coherence_level;
        logic [7:0]         entropy_level_out;
        logic [63:0]        chained_hash_out;
        logic [31:0]        stage_out;
        logic [SCORE_W-1:0] diversity_score;
    } t_out_beat;

    // h * 0x100000001B3 mod 2^64 as shift-add
    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        return h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
    endfunction

    // moving average, alpha 64/256
    function automatic logic [7:0] ema(input logic [7:0] s, input logic [7:0] x);
        logic [15:0] t;
        t = 16'(s) * 16'd192;
        return t[15:8] + {2'b00, x[7:2]};
    endfunction

endpackage

// ===== sv/message_hash_entropy_kernel_core.sv =====
// Top level of the message hash entropy kernel: sequencer, divider and mix multiplier
//
//  channel  direction  handshake                payload
//  in       input      i_in_valid / o_in_ready   i_in_data  (t_in_beat)
//  out      output     o_out_valid / i_out_ready o_out_data (t_out_beat)
//  cfg      input      APB psel/penable/pwrite   seed at byte address 0
//
// A byte beat is accepted, then hashed and counted (hash and count update).
// A last byte adds a chain fold, one pass of the one-bit-per-cycle divider
// for the transition term, a reciprocal multiply for the level, then seven passes
// through the shared 32x32 multiplier. A single-byte message skips the divider.
// A restart beat passes through S_RST, which uses the multiplier, and then S_RSTW.
// Reset is synchronous, active low; the kernel comes up as after a restart.
// Results wait in an output register; only the final write of a message stalls on it.
module message_hash_entropy_kernel_core
    import mhek_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "message_hash_entropy_kernel_core_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_BYTE, S_PREP, S_DIV, S_SCORE, S_LVL, S_AVG,
        S_MUL, S_MWB, S_OUT, S_RST, S_RSTW
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;

    logic [31:0]        r_seed, n_seed;
    logic [63:0]        r_chain, n_chain;
    logic [7:0]         r_coh, n_coh, r_ent, n_ent;
    logic [31:0]        r_stage, n_stage;
    logic [63:0]        r_msg, n_msg;
    logic [255:0]       r_seen, n_seen;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic [LEN_W-1:0]   r_trans, n_trans, r_len, n_len;
    logic [7:0]         r_prev, n_prev, r_byte, n_byte;
    logic               r_last, n_last;
    logic [SCORE_W-1:0] r_base, n_base, r_score, n_score;
    logic [DS_W-1:0]    r_rem, n_rem, r_dvs, n_dvs;
    logic [DV_W-1:0]    r_quo, n_quo;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [63:0]        r_prod, n_prod;
    logic [2:0]         r_idx, n_idx;
    logic [15:0]        r_mix [7];
    logic [15:0]        n_mix [7];
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    // shared units
    logic [63:0] hash_in, hash_res;
    logic [31:0] mul_a;
    logic [63:0] mul_res;
    logic [DS_W:0] div_trial;
    logic          div_ge;
    logic [20:0]   base_prod;
    logic [SCORE_W:0] score_sum;
    logic [18:0]   lvl_num;
    logic [38:0]   lvl_prod;
    logic [7:0]    ent_new;
    logic          cfg_wr;

    assign hash_res = fnv_mul(hash_in);
    assign mul_res  = 64'(mul_a) * 64'(GOLD);
    assign div_trial = {r_rem, r_quo[DV_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_dvs};
    assign base_prod = 21'(r_dist) * 21'd6000;
    assign score_sum = (SCORE_W+1)'(r_base) + (SCORE_W+1)'(r_quo[QT_W-1:0]);
    assign lvl_num   = 19'(r_score) * 19'd51;
    assign lvl_prod  = 39'(lvl_num) * 39'(LEVEL_RECIP);
    assign ent_new   = ema(r_ent, r_quo[7:0]);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign prdata = (paddr[2] == REG_SEED) ? r_seed : 32'd0;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // operand selects for the shared units
    always_comb begin
        hash_in = (r_state == S_PREP) ? (r_chain ^ r_msg) : (r_msg ^ {56'd0, r_byte});
        case (r_idx)
            3'd0:    mul_a = MIX_KEY ^ r_chain[63:32];
            3'd1:    mul_a = MIX_KEY ^ r_chain[31:0];
            3'd2:    mul_a = {24'd0, r_ent};
            3'd3:    mul_a = r_stage + 32'd1;
            3'd4:    mul_a = {16'd0, r_mix[0] ^ r_mix[1]};
            3'd5:    mul_a = {16'd0, r_mix[2] ^ r_mix[3]};
            3'd6:    mul_a = {16'd0, r_mix[4] ^ r_mix[5]};
            default: mul_a = 32'd0;
        endcase
        if (r_state == S_RST) begin
            mul_a = r_seed;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;   n_ret = r_ret;
        n_seed = r_seed;     n_chain = r_chain;  n_coh = r_coh;   n_ent = r_ent;
        n_stage = r_stage;   n_msg = r_msg;      n_seen = r_seen; n_dist = r_dist;
        n_trans = r_trans;   n_len = r_len;      n_prev = r_prev; n_byte = r_byte;
        n_last = r_last;     n_base = r_base;    n_score = r_score;
        n_rem = r_rem;       n_dvs = r_dvs;      n_quo = r_quo;   n_cnt = r_cnt;
        n_prod = r_prod;     n_idx = r_idx;      n_mix = r_mix;
        n_out_valid = r_out_valid;               n_out = r_out;

        if (cfg_wr) begin
            n_seed = pwdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_in_data.data_byte;
                    n_last = i_in_data.last_byte;
                    n_state = (i_in_data.op == OP_RESTART) ? S_RST : S_BYTE;
                end
            end
            // hash, seen map and counters for one byte
            S_BYTE: begin
                n_msg = hash_res;
                if (!r_seen[r_byte]) begin
                    n_seen[r_byte] = 1'b1;
                    n_dist = r_dist + DIST_W'(1);
                end
                if (r_len < LEN_W'(MAX_MSG_BYTES)) begin
                    if (r_len != '0 && r_byte != r_prev) begin
                        n_trans = r_trans + LEN_W'(1);
                    end
                    n_len = r_len + LEN_W'(1);
                end
                n_prev = r_byte;
                n_state = r_last ? S_PREP : S_IDLE;
            end
            // chain fold, distinct term, start transition division if the message has more than one byte
            S_PREP: begin
                n_chain = hash_res;
                n_base = base_prod[20:8];
                n_ret = S_SCORE;
                n_rem = '0;
                if (r_len > LEN_W'(1)) begin
                    n_quo = DV_W'(r_trans) * DV_W'(2000);
                    n_dvs = DS_W'(r_len - LEN_W'(1));
                    n_cnt = CNT_W'(DV_W);
                    n_state = S_DIV;
                end else begin
                    n_quo = '0;
                    n_state = S_SCORE;
                end
            end
            // restoring divider, one quotient bit per cycle
            S_DIV: begin
                n_rem = div_ge ? DS_W'(div_trial - {1'b0, r_dvs}) : DS_W'(div_trial);
                n_quo = {r_quo[DV_W-2:0], div_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = r_ret;
                end
            end
            // cap the score
            S_SCORE: begin
                n_score = (score_sum > (SCORE_W+1)'(SCORE_CAP)) ? SCORE_CAP
                                                              : score_sum[SCORE_W-1:0];
                n_state = S_LVL;
            end
            // scale the score to 0..255
            S_LVL: begin
                n_quo = DV_W'(lvl_prod[LEVEL_SHIFT+7:LEVEL_SHIFT]);
                n_state = S_AVG;
            end
            S_AVG: begin
                n_ent = ent_new;
                n_coh = ema(r_coh, 8'd255 - ent_new);
                n_stage = r_stage + 32'd1;
                n_idx = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod = mul_res;
                n_state = S_MWB;
            end
            S_MWB: begin
                n_mix[r_idx] = (r_idx == 3'd2 || r_idx == 3'd3) ? r_prod[31:16]
                                                                : r_prod[15:0];
                if (r_idx == 3'd6) begin
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 3'd1;
                    n_state = S_MUL;
                end
            end
            // publish the result beat and clear per-message state
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out.mix_u = r_mix[0];
                    n_out.mix_v = r_mix[1];
                    n_out.mix_psi = r_mix[2];
                    n_out.mix_chi = r_mix[3];
                    n_out.mix_rho = r_mix[4];
                    n_out.mix_delta = r_mix[5];
                    n_out.mix_sigma = r_mix[6];
                    n_out.coherence_level = r_coh;
                    n_out.entropy_level_out = r_ent;
                    n_out.chained_hash_out = r_chain;
                    n_out.stage_out = r_stage;
                    n_out.diversity_score = r_score;
                    n_msg = FNV_BASIS;
                    n_seen = '0;
                    n_dist = '0;
                    n_trans = '0;
                    n_len = '0;
                    n_prev = '0;
                    n_state = S_IDLE;
                end
            end
            S_RST: begin
                n_prod = mul_res;
                n_state = S_RSTW;
            end
            S_RSTW: begin
                n_chain = r_prod;
                n_coh = LEVEL_RESET;
                n_ent = LEVEL_RESET;
                n_stage = '0;
                n_msg = FNV_BASIS;
                n_seen = '0;
                n_dist = '0;
                n_trans = '0;
                n_len = '0;
                n_prev = '0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_seed <= SEED_RESET;
            r_chain <= CHAIN_RESET;
            r_coh <= LEVEL_RESET;
            r_ent <= LEVEL_RESET;
            r_stage <= '0;
            r_msg <= FNV_BASIS;
            r_seen <= '0;
            r_dist <= '0;
            r_trans <= '0;
            r_len <= '0;
            r_prev <= '0;
            r_idx <= '0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_seed <= n_seed;
            r_chain <= n_chain;
            r_coh <= n_coh;
            r_ent <= n_ent;
            r_stage <= n_stage;
            r_msg <= n_msg;
            r_seen <= n_seen;
            r_dist <= n_dist;
            r_trans <= n_trans;
            r_len <= n_len;
            r_prev <= n_prev;
            r_idx <= n_idx;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_byte <= n_byte;
        r_last <= n_last;
        r_base <= n_base;
        r_score <= n_score;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
        r_prod <= n_prod;
        r_mix <= n_mix;
        r_out <= n_out;
    end

    // checks
    `MHEK_ASSERT(a_dist_pop, $countones(r_seen) == int'(r_dist))
    `MHEK_ASSERT(a_len_cap, r_len <= LEN_W'(MAX_MSG_BYTES))
    `MHEK_ASSERT(a_trans_len, (r_len == '0 && r_trans == '0) || r_trans < r_len)
    `MHEK_ASSERT(a_busy_after_beat, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `MHEK_ASSERT_RST(a_rst_out, !i_rst_n |=> !o_out_valid)

endmodule

// ===== test/message_hash_entropy_kernel_core_tb.sv =====
// Self-checking testbench for the message hash entropy kernel core
module message_hash_entropy_kernel_core_tb;
    import mhek_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_SEED = 3'd0;
    localparam int unsigned MSG_LIMIT = 256;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_beat   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    message_hash_entropy_kernel_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // kernel model state
    logic [31:0] seed_reg;
    logic [63:0] chain_h;
    logic [7:0]  coh_lvl;
    logic [7:0]  ent_lvl;
    logic [31:0] stage_cnt;
    logic [63:0] msg_h;
    logic [255:0] seen;
    int unsigned distinct_n;
    int unsigned trans_n;
    int unsigned len_n;
    logic [7:0]  prev_b;

    t_in_beat  pending_beats[$];
    t_out_beat expected_mixes[$];

    int unsigned error_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned recv_hold;
    int unsigned quiet_cycles;
    logic        o_in_ready_q;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] gold_mul(input logic [31:0] a);
        logic [63:0] p;
        p = 64'(a) * 64'(GOLD);
        return p[31:0];
    endfunction

    function automatic logic [7:0] smooth(input logic [7:0] s, input logic [31:0] x);
        logic [31:0] t;
        t = ((32'd192 * 32'(s)) >> 8) + ((32'd64 * x) >> 8);
        return t[7:0];
    endfunction

    task automatic clear_msg();
        msg_h = FNV_BASIS;
        seen = '0;
        distinct_n = 0;
        trans_n = 0;
        len_n = 0;
        prev_b = 8'd0;
    endtask

    task automatic restart_kernel();
        chain_h = 64'(seed_reg) * 64'(GOLD);
        coh_lvl = 8'd128;
        ent_lvl = 8'd128;
        stage_cnt = 32'd0;
        clear_msg();
    endtask

    // advance the model by one accepted beat, queue a result on a last byte
    task automatic predict_mixes(input t_in_beat b);
        int unsigned score;
        t_out_beat r;
        logic [31:0] u, v, psi, chi, rho, dlt;
        if (b.op == OP_RESTART) begin
            restart_kernel();
            return;
        end
        msg_h = (msg_h ^ 64'(b.data_byte)) * 64'h100000001B3;
        if (!seen[b.data_byte]) begin
            seen[b.data_byte] = 1'b1;
            distinct_n++;
        end
        if (len_n < MSG_LIMIT) begin
            if (len_n > 0 && b.data_byte != prev_b) trans_n++;
            len_n++;
        end
        prev_b = b.data_byte;
        if (!b.last_byte) return;
        score = distinct_n * 6000 / 256;
        if (len_n > 1) score += trans_n * 2000 / (len_n - 1);
        if (score > 8000) score = 8000;
        chain_h = (chain_h ^ msg_h) * 64'h100000001B3;
        ent_lvl = smooth(ent_lvl, score * 255 / 8000);
        coh_lvl = smooth(coh_lvl, 32'd255 - 32'(ent_lvl));
        stage_cnt = stage_cnt + 32'd1;
        u = gold_mul(MIX_KEY ^ chain_h[63:32]) & 32'hFFFF;
        v = gold_mul(MIX_KEY ^ chain_h[31:0]) & 32'hFFFF;
        psi = gold_mul(32'(ent_lvl)) >> 16;
        chi = gold_mul(stage_cnt + 32'd1) >> 16;
        rho = gold_mul(u ^ v) & 32'hFFFF;
        dlt = gold_mul(psi ^ chi) & 32'hFFFF;
        r.mix_u = u[15:0];
        r.mix_v = v[15:0];
        r.mix_psi = psi[15:0];
        r.mix_chi = chi[15:0];
        r.mix_rho = rho[15:0];
        r.mix_delta = dlt[15:0];
        r.mix_sigma = 16'(gold_mul(rho ^ dlt));
        r.coherence_level = coh_lvl;
        r.entropy_level_out = ent_lvl;
        r.chained_hash_out = chain_h;
        r.stage_out = stage_cnt;
        r.diversity_score = SCORE_W'(score);
        expected_mixes.push_back(r);
        clear_msg();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // input driver: beats change at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready_q) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // acceptance seen at the last rising edge
    always @(posedge i_clk) begin
        o_in_ready_q <= i_in_valid && o_in_ready && i_rst_n;
        if (i_rst_n && i_in_valid && o_in_ready) predict_mixes(i_in_data);
    end

    // receiver ready, with an optional long hold-off
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_out_beat w;
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("message_hash_entropy_kernel_core_tb: done, errors");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_mixes.size() == 0) begin
                report_mismatch("unexpected beat", 64'(o_out_data.stage_out), 64'd0);
            end else begin
                w = expected_mixes.pop_front();
                if (o_out_data.mix_u !== w.mix_u)
                    report_mismatch("mix_u", 64'(o_out_data.mix_u), 64'(w.mix_u));
                if (o_out_data.mix_v !== w.mix_v)
                    report_mismatch("mix_v", 64'(o_out_data.mix_v), 64'(w.mix_v));
                if (o_out_data.mix_psi !== w.mix_psi)
                    report_mismatch("mix_psi", 64'(o_out_data.mix_psi), 64'(w.mix_psi));
                if (o_out_data.mix_chi !== w.mix_chi)
                    report_mismatch("mix_chi", 64'(o_out_data.mix_chi), 64'(w.mix_chi));
                if (o_out_data.mix_rho !== w.mix_rho)
                    report_mismatch("mix_rho", 64'(o_out_data.mix_rho), 64'(w.mix_rho));
                if (o_out_data.mix_delta !== w.mix_delta)
                    report_mismatch("mix_delta", 64'(o_out_data.mix_delta),
                                    64'(w.mix_delta));
                if (o_out_data.mix_sigma !== w.mix_sigma)
                    report_mismatch("mix_sigma", 64'(o_out_data.mix_sigma),
                                    64'(w.mix_sigma));
                if (o_out_data.coherence_level !== w.coherence_level)
                    report_mismatch("coherence", 64'(o_out_data.coherence_level),
                                    64'(w.coherence_level));
                if (o_out_data.entropy_level_out !== w.entropy_level_out)
                    report_mismatch("entropy", 64'(o_out_data.entropy_level_out),
                                    64'(w.entropy_level_out));
                if (o_out_data.chained_hash_out !== w.chained_hash_out)
                    report_mismatch("chain", o_out_data.chained_hash_out,
                                    w.chained_hash_out);
                if (o_out_data.stage_out !== w.stage_out)
                    report_mismatch("stage", 64'(o_out_data.stage_out), 64'(w.stage_out));
                if (o_out_data.diversity_score !== w.diversity_score)
                    report_mismatch("score", 64'(o_out_data.diversity_score),
                                    64'(w.diversity_score));
            end
        end
    end

    function automatic t_in_beat mk_beat(input logic op, input logic [7:0] d,
                                         input logic lst);
        t_in_beat b;
        b.op = op;
        b.data_byte = d;
        b.last_byte = lst;
        return b;
    endfunction

    // one message of n bytes drawn from a small or full alphabet, or in runs of repeated bytes
    task automatic queue_message(input int unsigned n, input int unsigned mode);
        logic [7:0] d;
        for (int unsigned k = 0; k < n; k++) begin
            case (mode)
                0: d = 8'($urandom);
                1: d = 8'($urandom_range(3));
                default: d = (k % 7 == 0) ? 8'($urandom) : d;
            endcase
            pending_beats.push_back(mk_beat(OP_BYTE, d, k == n - 1));
        end
    endtask

    // wait until everything sent is answered and the core has gone quiet
    task automatic drain();
        while (pending_beats.size() > 0 || i_in_valid || expected_mixes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup then access cycle
    task automatic write_seed(input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_SEED; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        seed_reg = val;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 5) begin
                pending_beats.push_back(mk_beat(OP_RESTART, 8'($urandom), 1'($urandom)));
                sent++;
            end else begin
                len = (r < 8) ? $urandom_range(257, 300) : $urandom_range(1, 12);
                queue_message(len, $urandom_range(2));
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        quiet_cycles = 0;
        o_in_ready_q = 1'b0;
        seed_reg = SEED_RESET;
        restart_kernel();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single byte, extremes, repeats, restart, long message
        pending_beats.push_back(mk_beat(OP_BYTE, 8'h00, 1'b1));
        pending_beats.push_back(mk_beat(OP_BYTE, 8'hFF, 1'b1));
        pending_beats.push_back(mk_beat(OP_BYTE, 8'hAA, 1'b0));
        pending_beats.push_back(mk_beat(OP_BYTE, 8'hAA, 1'b1));
        pending_beats.push_back(mk_beat(OP_BYTE, 8'h55, 1'b0));
        pending_beats.push_back(mk_beat(OP_BYTE, 8'hAA, 1'b0));
        pending_beats.push_back(mk_beat(OP_BYTE, 8'h55, 1'b1));
        pending_beats.push_back(mk_beat(OP_RESTART, 8'hFF, 1'b1));
        pending_beats.push_back(mk_beat(OP_BYTE, 8'h01, 1'b1));
        drain();
        // every value once, then past the length limit
        for (int k = 0; k < 256; k++)
            pending_beats.push_back(mk_beat(OP_BYTE, 8'(k), 1'b0));
        for (int k = 0; k < 20; k++)
            pending_beats.push_back(mk_beat(OP_BYTE, 8'(k * 37), k == 19));
        drain();

        write_seed(32'h0000_0000);
        pending_beats.push_back(mk_beat(OP_RESTART, 8'h00, 1'b0));
        send_idle_pct = 35; recv_idle_pct = 82;
        random_phase(380);
        drain();

        write_seed(32'hFFFF_FFFF);
        pending_beats.push_back(mk_beat(OP_RESTART, 8'h00, 1'b0));
        send_idle_pct = 82; recv_idle_pct = 35;
        random_phase(380);
        drain();

        write_seed(32'($urandom));
        pending_beats.push_back(mk_beat(OP_RESTART, 8'h00, 1'b0));
        send_idle_pct = 0; recv_idle_pct = 0;
        // receiver holds off while messages keep coming
        @(negedge i_clk);
        recv_hold = 600;
        random_phase(380);
        drain();

        if (error_count == 0) begin
            $display("message_hash_entropy_kernel_core_tb: done, clean");
        end else begin
            $display("message_hash_entropy_kernel_core_tb: done, errors");
        end
        $finish;
    end

endmodule
